>>> rtl/jedec_flash_command_decoder_assert.svh
// Assertion macros used by the flash command decoder RTL.
`ifndef JEDEC_FLASH_COMMAND_DECODER_ASSERT_SVH
`define JEDEC_FLASH_COMMAND_DECODER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define JFCD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define JFCD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/jfcd_pkg.sv
package jfcd_pkg;

   // Lock search lanes: blocks checked per cycle
   localparam int LANES = 4;

   // Access kinds
   localparam logic KIND_READ  = 1'b0;
   localparam logic KIND_WRITE = 1'b1;

   // Command addresses and data codes
   localparam logic [31:0] CMD_ADDR_A       = 32'hFFFF_5555;
   localparam logic [31:0] CMD_ADDR_B       = 32'hFFFF_2AAA;
   localparam logic [7:0]  DATA_UNLOCK1     = 8'hAA;
   localparam logic [7:0]  DATA_UNLOCK2     = 8'h55;
   localparam logic [7:0]  DATA_ERASE_SETUP = 8'h80;
   localparam logic [7:0]  DATA_ERASE_BLOCK = 8'h50;
   localparam logic [7:0]  DATA_PROGRAM     = 8'hA0;
   localparam logic [7:0]  ERASED_BYTE      = 8'hFF;

   // Lock register bits
   localparam int         LK_WRITE_BIT = 0;
   localparam int         LK_DOWN_BIT  = 1;
   localparam int         LK_READ_BIT  = 2;
   localparam logic [2:0] LOCK_RESET   = 3'b001;

   // Control register reset values
   localparam logic [31:0] ARRAY_BASE_RESET  = 32'hFFF8_0000;
   localparam logic [31:0] LOCK_BASE_RESET   = 32'hFFB8_0002;
   localparam logic [24:0] LOCK_STRIDE_RESET = 25'h001_0000;
   localparam logic [31:0] MAKER_ADDR_RESET  = 32'hFFBC_0000;
   localparam logic [31:0] PART_ADDR_RESET   = 32'hFFBC_0001;
   localparam logic [7:0]  MAKER_CODE_RESET  = 8'd157;
   localparam logic [7:0]  PART_CODE_RESET   = 8'd110;

   // Control register indexes
   typedef enum logic [2:0] {
      CSR_ARRAY_BASE  = 3'd0,
      CSR_LOCK_BASE   = 3'd1,
      CSR_LOCK_STRIDE = 3'd2,
      CSR_MAKER_ADDR  = 3'd3,
      CSR_PART_ADDR   = 3'd4,
      CSR_MAKER_CODE  = 3'd5,
      CSR_PART_CODE   = 3'd6
   } csr_index_type;

   // Result status codes
   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_LOCKED   = 2'd1,
      STAT_UNMAPPED = 2'd2,
      STAT_LOCKDOWN = 2'd3
   } status_type;

   // Command sequence phase
   typedef enum logic [6:0] {
      PH_IDLE        = 7'b0000001,
      PH_AA          = 7'b0000010,
      PH_UNLOCKED    = 7'b0000100,
      PH_PROGRAM     = 7'b0001000,
      PH_ERASE_SETUP = 7'b0010000,
      PH_ERASE_AA    = 7'b0100000,
      PH_ERASE_READY = 7'b1000000
   } phase_type;

   // Item sequencer
   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_SEARCH = 6'b000010,
      ST_LOCK   = 6'b000100,
      ST_EXEC   = 6'b001000,
      ST_FILL   = 6'b010000,
      ST_OUT    = 6'b100000
   } state_type;

endpackage

>>> rtl/jedec_flash_command_decoder.sv
// Channel   | Direction | Handshake              | Payload
// req       | in        | req_valid / req_ready  | req_kind, req_bus_address, req_write_byte
// rsp       | out       | rsp_valid / rsp_ready  | rsp_read_byte, rsp_status
// csr       | in        | csr_write_enable       | csr_index, csr_write_data
//
// An item passes through accept, lock-register search at four blocks per cycle,
// lock/array memory read, execute and result load. A block erase adds a fill of
// the block: the array memory port writes one byte a cycle. After reset the whole
// array memory is filled with 0xFF with req_ready low; csr writes are taken meanwhile.
// A new item is taken while a result waits in the rsp register; a stalled rsp holds
// the next result in the output step until the register frees.
`include "jedec_flash_command_decoder_assert.svh"

module jedec_flash_command_decoder import jfcd_pkg::*; #(
   parameter int BLOCK_COUNT = 8,
   parameter int BLOCK_BYTES = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [31:0] req_bus_address,
   input  logic [7:0]  req_write_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_read_byte,
   output logic [1:0]  rsp_status,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_write_data
);

   localparam int ARRAY_BYTES = BLOCK_COUNT * BLOCK_BYTES;
   localparam int AW = $clog2(ARRAY_BYTES);
   localparam int BW = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
   localparam int KW = $clog2(BLOCK_COUNT + LANES);

   // Control registers
   logic [31:0] array_base_ff, lock_base_ff, maker_addr_ff, part_addr_ff;
   logic [24:0] lock_stride_ff;
   logic [7:0]  maker_code_ff, part_code_ff;

   // Sequencer and command phase
   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;

   // Item being worked on
   logic        kind_ff, kind_in;
   logic [31:0] addr_ff, addr_in;
   logic [7:0]  data_ff, data_in;
   logic [31:0] off_ff, off_in;

   // Block search
   logic [31:0]   lock_rem_ff, lock_rem_in;
   logic [31:0]   off_rem_ff, off_rem_in;
   logic [KW-1:0] k_ff, k_in;
   logic          lock_found_ff, lock_found_in;
   logic [BW-1:0] lock_blk_ff, lock_blk_in;
   logic          arr_found_ff, arr_found_in;
   logic [BW-1:0] arr_blk_ff, arr_blk_in;
   logic          lane_lock_hit, lane_arr_hit, search_last;
   logic [BW-1:0] lane_lock_blk, lane_arr_blk;

   // Memories and their read registers
   logic [7:0]          arr_mem [ARRAY_BYTES];
   logic [2:0]          lock_mem [BLOCK_COUNT];
   logic [BLOCK_COUNT-1:0] lock_vld_ff;
   logic [7:0]          arr_q_ff;
   logic [2:0]          lock_q_ff;
   logic                lock_qv_ff;
   logic                arr_re, arr_we, lock_re, lock_we;
   logic [AW-1:0]       arr_wa;
   logic [7:0]          arr_wd;
   logic [BW-1:0]       lock_sel;
   logic [2:0]          lock_now;

   // Fill walker (reset clear and block erase)
   logic [AW-1:0] fill_ptr_ff, fill_ptr_in, fill_end_ff, fill_end_in;
   logic          fill_rsp_ff, fill_rsp_in;
   logic [AW-1:0] erase_start;

   // Result hold and output register
   logic [7:0]  res_byte_ff, res_byte_in;
   status_type  res_stat_ff, res_stat_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_byte_ff, rsp_byte_in;
   status_type  rsp_stat_ff, rsp_stat_in;

   // Execute-stage decisions
   logic at_a, at_b, go_fill, rsp_load;

   // Control register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         array_base_ff  <= ARRAY_BASE_RESET;
         lock_base_ff   <= LOCK_BASE_RESET;
         lock_stride_ff <= LOCK_STRIDE_RESET;
         maker_addr_ff  <= MAKER_ADDR_RESET;
         part_addr_ff   <= PART_ADDR_RESET;
         maker_code_ff  <= MAKER_CODE_RESET;
         part_code_ff   <= PART_CODE_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_ARRAY_BASE:  array_base_ff  <= csr_write_data;
            CSR_LOCK_BASE:   lock_base_ff   <= csr_write_data;
            CSR_LOCK_STRIDE: lock_stride_ff <= csr_write_data[24:0];
            CSR_MAKER_ADDR:  maker_addr_ff  <= csr_write_data;
            CSR_PART_ADDR:   part_addr_ff   <= csr_write_data;
            CSR_MAKER_CODE:  maker_code_ff  <= csr_write_data[7:0];
            CSR_PART_CODE:   part_code_ff   <= csr_write_data[7:0];
            default: ;
         endcase
      end
   end

   // Search lanes: lowest matching lane wins (with zero stride, an address at the lock base matches every lane)
   always_comb begin
      logic [KW-1:0] lane_idx;
      lane_lock_hit = 1'b0;
      lane_lock_blk = '0;
      lane_arr_hit  = 1'b0;
      lane_arr_blk  = '0;
      for (int j = LANES - 1; j >= 0; j--) begin
         lane_idx = k_ff + KW'(j);
         if (lane_idx < KW'(BLOCK_COUNT)) begin
            if (lock_rem_ff == 32'(lock_stride_ff) * 32'(j)) begin
               lane_lock_hit = 1'b1;
               lane_lock_blk = BW'(lane_idx);
            end
            if (off_rem_ff >= 32'(j) * 32'(BLOCK_BYTES) &&
                off_rem_ff < (32'(j) + 32'd1) * 32'(BLOCK_BYTES)) begin
               lane_arr_hit = 1'b1;
               lane_arr_blk = BW'(lane_idx);
            end
         end
      end
      search_last = (int'(k_ff) + LANES) >= BLOCK_COUNT;
   end

   // Memory port control
   assign lock_sel    = lock_found_ff ? lock_blk_ff : arr_blk_ff;
   assign lock_re     = (state_ff == ST_LOCK);
   assign arr_re      = (state_ff == ST_LOCK);
   assign lock_now    = lock_qv_ff ? lock_q_ff : LOCK_RESET;
   assign at_a        = (addr_ff == CMD_ADDR_A);
   assign at_b        = (addr_ff == CMD_ADDR_B);
   assign erase_start = AW'(32'(arr_blk_ff) * 32'(BLOCK_BYTES));
   assign rsp_load    = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);

   // Execute: decode, lock check, command phase, writes
   always_comb begin
      res_byte_in = res_byte_ff;
      res_stat_in = res_stat_ff;
      phase_in    = phase_ff;
      lock_we     = 1'b0;
      arr_we      = 1'b0;
      arr_wa      = off_ff[AW-1:0];
      arr_wd      = arr_q_ff & data_ff;
      go_fill     = 1'b0;
      if (state_ff == ST_FILL) begin
         arr_we = 1'b1;
         arr_wa = fill_ptr_ff;
         arr_wd = ERASED_BYTE;
      end else if (state_ff == ST_EXEC) begin
         res_byte_in = 8'h00;
         res_stat_in = STAT_OK;
         if (kind_ff == KIND_READ) begin
            if (addr_ff == maker_addr_ff) begin
               res_byte_in = maker_code_ff;
            end else if (addr_ff == part_addr_ff) begin
               res_byte_in = part_code_ff;
            end else if (lock_found_ff) begin
               res_byte_in = {5'b0, lock_now};
            end else if (arr_found_ff) begin
               if (lock_now[LK_READ_BIT]) begin
                  res_stat_in = STAT_LOCKED;
               end else begin
                  res_byte_in = arr_q_ff;
               end
            end else begin
               res_stat_in = STAT_UNMAPPED;
            end
         end else if (lock_found_ff) begin
            if (lock_now[LK_DOWN_BIT]) begin
               res_stat_in = STAT_LOCKDOWN;
            end else begin
               lock_we = 1'b1;
            end
            phase_in = PH_IDLE;
         end else begin
            if (!at_a && !at_b && !arr_found_ff) begin
               res_stat_in = STAT_UNMAPPED;
            end
            phase_in = PH_IDLE;
            case (phase_ff)
               PH_IDLE: begin
                  if (at_a && data_ff == DATA_UNLOCK1) phase_in = PH_AA;
               end
               PH_ERASE_SETUP: begin
                  if (at_a && data_ff == DATA_UNLOCK1) phase_in = PH_ERASE_AA;
               end
               PH_AA: begin
                  if (at_b && data_ff == DATA_UNLOCK2) phase_in = PH_UNLOCKED;
               end
               PH_ERASE_AA: begin
                  if (at_b && data_ff == DATA_UNLOCK2) phase_in = PH_ERASE_READY;
               end
               PH_UNLOCKED: begin
                  if (at_a && data_ff == DATA_PROGRAM) begin
                     phase_in = PH_PROGRAM;
                  end else if (at_a && data_ff == DATA_ERASE_SETUP) begin
                     phase_in = PH_ERASE_SETUP;
                  end
               end
               PH_PROGRAM: begin
                  if (arr_found_ff) begin
                     if (lock_now[LK_WRITE_BIT]) begin
                        res_stat_in = STAT_LOCKED;
                     end else begin
                        arr_we = 1'b1;
                     end
                  end
               end
               PH_ERASE_READY: begin
                  if (data_ff == DATA_ERASE_BLOCK && arr_found_ff) begin
                     if (lock_now[LK_WRITE_BIT]) begin
                        res_stat_in = STAT_LOCKED;
                     end else begin
                        go_fill = 1'b1;
                     end
                  end
               end
               default: ;
            endcase
         end
      end
   end

   // Sequencer and search next state
   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      addr_in       = addr_ff;
      data_in       = data_ff;
      off_in        = off_ff;
      lock_rem_in   = lock_rem_ff;
      off_rem_in    = off_rem_ff;
      k_in          = k_ff;
      lock_found_in = lock_found_ff;
      lock_blk_in   = lock_blk_ff;
      arr_found_in  = arr_found_ff;
      arr_blk_in    = arr_blk_ff;
      fill_ptr_in   = fill_ptr_ff;
      fill_end_in   = fill_end_ff;
      fill_rsp_in   = fill_rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               kind_in       = req_kind;
               addr_in       = req_bus_address;
               data_in       = req_write_byte;
               off_in        = req_bus_address - array_base_ff;
               off_rem_in    = req_bus_address - array_base_ff;
               lock_rem_in   = req_bus_address - lock_base_ff;
               k_in          = '0;
               lock_found_in = 1'b0;
               arr_found_in  = 1'b0;
               state_in      = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            lock_rem_in = lock_rem_ff - 32'(lock_stride_ff) * 32'(LANES);
            off_rem_in  = off_rem_ff - 32'(LANES) * 32'(BLOCK_BYTES);
            k_in        = k_ff + KW'(LANES);
            if (!lock_found_ff && lane_lock_hit) begin
               lock_found_in = 1'b1;
               lock_blk_in   = lane_lock_blk;
            end
            if (!arr_found_ff && lane_arr_hit) begin
               arr_found_in = 1'b1;
               arr_blk_in   = lane_arr_blk;
            end
            if (search_last) state_in = ST_LOCK;
         end
         ST_LOCK: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (go_fill) begin
               fill_ptr_in = erase_start;
               fill_end_in = erase_start + AW'(BLOCK_BYTES - 1);
               fill_rsp_in = 1'b1;
               state_in    = ST_FILL;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_FILL: begin
            if (fill_ptr_ff == fill_end_ff) begin
               state_in = fill_rsp_ff ? ST_OUT : ST_IDLE;
            end else begin
               fill_ptr_in = fill_ptr_ff + AW'(1);
            end
         end
         ST_OUT: begin
            if (rsp_load) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_stat_in  = rsp_stat_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = res_byte_ff;
         rsp_stat_in  = res_stat_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         phase_ff     <= PH_IDLE;
         fill_ptr_ff  <= '0;
         fill_end_ff  <= AW'(ARRAY_BYTES - 1);
         fill_rsp_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         lock_vld_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         fill_ptr_ff  <= fill_ptr_in;
         fill_end_ff  <= fill_end_in;
         fill_rsp_ff  <= fill_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
         if (lock_we) lock_vld_ff[lock_blk_ff] <= 1'b1;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      addr_ff       <= addr_in;
      data_ff       <= data_in;
      off_ff        <= off_in;
      lock_rem_ff   <= lock_rem_in;
      off_rem_ff    <= off_rem_in;
      k_ff          <= k_in;
      lock_found_ff <= lock_found_in;
      lock_blk_ff   <= lock_blk_in;
      arr_found_ff  <= arr_found_in;
      arr_blk_ff    <= arr_blk_in;
      res_byte_ff   <= res_byte_in;
      res_stat_ff   <= res_stat_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_stat_ff   <= rsp_stat_in;
   end

   // Flash array memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (arr_we) arr_mem[arr_wa] <= arr_wd;
      if (arr_re) arr_q_ff <= arr_mem[off_ff[AW-1:0]];
   end

   // Lock register memory; entries without a valid bit read as the reset value
   always_ff @(posedge clock) begin
      if (lock_we) lock_mem[lock_blk_ff] <= data_ff[2:0];
      if (lock_re) begin
         lock_q_ff  <= lock_mem[lock_sel];
         lock_qv_ff <= lock_vld_ff[lock_sel];
      end
   end

   assign req_ready     = (state_ff == ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_byte = rsp_byte_ff;
   assign rsp_status    = rsp_stat_ff;

   // Checks
   `JFCD_ASSERT_NEXT(a_accept_starts_search, clock, reset, req_valid && req_ready,
      state_ff == ST_SEARCH, "accepted item did not enter the block search")
   `JFCD_ASSERT_NOW(a_array_write_window, clock, reset, arr_we,
      state_ff == ST_EXEC || state_ff == ST_FILL, "array written outside execute or fill")
   `JFCD_ASSERT_NOW(a_lock_write_allowed, clock, reset, lock_we,
      state_ff == ST_EXEC && lock_found_ff && !lock_now[LK_DOWN_BIT],
      "lock register written while locked down or not decoded")
   `JFCD_ASSERT_NOW(a_no_accept_in_fill, clock, reset, state_ff == ST_FILL,
      !req_ready, "item accepted during array fill")
   `JFCD_ASSERT_NOW(a_rsp_from_out, clock, reset, $rose(rsp_valid_ff),
      $past(state_ff == ST_OUT), "result raised outside the output step")

endmodule
